FILE: hdl/pqcm_pkg.sv
// ----------------------------------------------------------------------------
// pqcm_pkg
// Types and constants shared by the PRS QPSK comb mapper: register indexes,
// the controller state type, comb sizes and the comb staircase offsets.
// ----------------------------------------------------------------------------
package pqcm_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_COMB_CODE      = 3'd0;
   localparam logic [2:0] CSR_RE_OFFSET      = 3'd1;
   localparam logic [2:0] CSR_RB_OFFSET      = 3'd2;
   localparam logic [2:0] CSR_CARRIER_OFFSET = 3'd3;
   localparam logic [2:0] CSR_FFT_SIZE       = 3'd4;
   localparam logic [2:0] CSR_NUM_RB         = 3'd5;
   localparam logic [2:0] CSR_AMPLITUDE      = 3'd6;
   localparam logic [2:0] CSR_SYMBOL_START   = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // grid and sequence constants
   localparam int                 FFT_W           = 13;
   localparam int                 SC_W            = 12;
   localparam logic [FFT_W-1:0]   MAX_FFT         = 13'd4096;
   localparam logic signed [15:0] QPSK_LEVEL      = 16'sd23170;
   localparam logic [3:0]         MAX_PRS_SYMBOLS = 4'd12;
   localparam logic [3:0]         LAST_PAIR       = 4'd15;
   localparam int                 START_W         = 14;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef logic [3:0] stair_row_type [12];

   localparam stair_row_type STAIR_TAB [4] = '{
      '{4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1},
      '{4'd0, 4'd2, 4'd1, 4'd3, 4'd0, 4'd2, 4'd1, 4'd3, 4'd0, 4'd2, 4'd1, 4'd3},
      '{4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd5, 4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd5},
      '{4'd0, 4'd6, 4'd3, 4'd9, 4'd1, 4'd7, 4'd4, 4'd10, 4'd2, 4'd8, 4'd5, 4'd11}
   };

   localparam logic [3:0] COMB_TAB [4] = '{4'd2, 4'd4, 4'd6, 4'd12};

endpackage

FILE: hdl/pqcm_rem.sv
// ----------------------------------------------------------------------------
// pqcm_rem
// Bit-serial remainder unit: reduces a dividend modulo a 13-bit divisor,
// one dividend bit per cycle, restoring style.
// ----------------------------------------------------------------------------
module pqcm_rem #(
   parameter int DW = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DW-1:0]                   dividend,
   input  logic [pqcm_pkg::FFT_W-1:0]      divisor,
   output logic                            busy,
   output logic                            done,
   output logic [pqcm_pkg::SC_W-1:0]       remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [DW-1:0]                div_ff, div_in;
   logic [pqcm_pkg::SC_W-1:0]    rem_ff, rem_in;
   logic                         done_ff, done_in;
   logic [pqcm_pkg::FFT_W-1:0]   trial;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, div_ff[DW-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CW'(DW);
         div_in = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         div_in  = {div_ff[DW-2:0], 1'b0};
         done_in = (cnt_ff == CW'(1));
         if (trial >= divisor) begin
            rem_in = pqcm_pkg::SC_W'(trial - divisor);
         end else begin
            rem_in = trial[pqcm_pkg::SC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy      = (cnt_ff != '0);
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/prs_qpsk_comb_mapper_core.sv
// ----------------------------------------------------------------------------
// prs_qpsk_comb_mapper_core
// Maps gold-sequence words onto comb-spaced PRS resource elements as
// amplitude-scaled QPSK samples, one element per cycle while rsp_stall allows.
//
//   channel   dir   handshake              word
//   req_      in    req_valid/req_stall    gold word, symbol offset, first flag
//   rsp_      out   rsp_valid/rsp_stall    one resource element
//   csr_      in    csr_valid/csr_ready    register index and write data
//
// A word yields up to 16 elements at one per cycle unless rsp_stall holds the
// output, shifted two gold bits at a time; a first word first waits while the
// bit-serial remainder unit reduces the start subcarrier modulo the fft size.
// After reset and after each register write the step and wrap values are
// recomputed, and req_stall stays high until both remainder units are done.
// The next word is taken as soon as the last element of a word sits in the
// output register, even while rsp_stall holds it there.
// ----------------------------------------------------------------------------
module prs_qpsk_comb_mapper_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_gold_word,
   input  logic [3:0]                           req_symbol_offset,
   input  logic                                 req_first_word,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [4:0]                           rsp_symbol_index,
   output logic [11:0]                          rsp_subcarrier,
   output logic signed [15:0]                   rsp_sample_real,
   output logic signed [15:0]                   rsp_sample_imag,
   output logic                                 rsp_last_of_word,
   output logic                                 rsp_last_of_symbol,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pqcm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pqcm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // configuration registers
   logic [1:0]                  comb_code_ff;
   logic [3:0]                  re_offset_ff;
   logic [8:0]                  rb_offset_ff;
   logic [11:0]                 carrier_offset_ff;
   logic [12:0]                 fft_size_ff;
   logic [8:0]                  num_rb_ff;
   logic signed [15:0]          amplitude_ff;
   logic [3:0]                  symbol_start_ff;
   logic                        cfg_dirty_ff;

   // mapper state
   pqcm_pkg::state_type         state_ff, state_in;
   logic [11:0]                 ns_ff, ns_in;
   logic [11:0]                 nsr_ff, nsr_in;
   logic [11:0]                 el_ff, el_in;
   logic [4:0]                  sym_ff, sym_in;
   logic [31:0]                 word_ff, word_in;
   logic [3:0]                  cnt_ff, cnt_in;
   logic signed [15:0]          pos_ff, neg_ff;
   logic [11:0]                 step_ff;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [4:0]                  rsp_sym_ff;
   logic [11:0]                 rsp_sc_ff;
   logic signed [15:0]          rsp_re_ff, rsp_im_ff;
   logic                        rsp_low_ff, rsp_los_ff;

   logic                        csr_we;
   logic                        accept;
   logic                        emit;
   logic                        cfg_start;
   logic                        cfg_busy;
   logic                        last_word;
   logic [pqcm_pkg::FFT_W-1:0]  fft_eff;
   logic [3:0]                  comb;
   logic [3:0]                  kp;
   logic [4:0]                  re_sum;
   logic [3:0]                  re_mod;
   logic [pqcm_pkg::START_W-1:0] start_sum;
   logic [11:0]                 el_load;
   logic [pqcm_pkg::FFT_W-1:0]  step_sum;
   logic [11:0]                 ns_next;
   logic signed [31:0]          prod_pos, prod_neg;

   logic                        a_start, a_busy, a_done;
   logic [pqcm_pkg::START_W-1:0] a_dividend;
   logic [11:0]                 a_rem;
   logic                        b_busy, b_done;
   logic [11:0]                 b_rem;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         comb_code_ff      <= '0;
         re_offset_ff      <= '0;
         rb_offset_ff      <= '0;
         carrier_offset_ff <= '0;
         fft_size_ff       <= 13'd4096;
         num_rb_ff         <= '0;
         amplitude_ff      <= '0;
         symbol_start_ff   <= '0;
         cfg_dirty_ff      <= 1'b1;
      end else begin
         if (csr_we) begin
            cfg_dirty_ff <= 1'b1;
         end else if (cfg_start) begin
            cfg_dirty_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               pqcm_pkg::CSR_COMB_CODE:      comb_code_ff      <= csr_wdata[1:0];
               pqcm_pkg::CSR_RE_OFFSET:      re_offset_ff      <= csr_wdata[3:0];
               pqcm_pkg::CSR_RB_OFFSET:      rb_offset_ff      <= csr_wdata[8:0];
               pqcm_pkg::CSR_CARRIER_OFFSET: carrier_offset_ff <= csr_wdata[11:0];
               pqcm_pkg::CSR_FFT_SIZE:       fft_size_ff       <= csr_wdata[12:0];
               pqcm_pkg::CSR_NUM_RB:         num_rb_ff         <= csr_wdata[8:0];
               pqcm_pkg::CSR_AMPLITUDE:      amplitude_ff      <= csr_wdata;
               pqcm_pkg::CSR_SYMBOL_START:   symbol_start_ff   <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // derived configuration
   assign comb    = pqcm_pkg::COMB_TAB[comb_code_ff];
   assign fft_eff = (fft_size_ff == '0 || fft_size_ff > pqcm_pkg::MAX_FFT) ?
                    pqcm_pkg::MAX_FFT : fft_size_ff;

   // both qpsk levels scaled once, ahead of any element
   assign prod_pos = 32'(amplitude_ff) * 32'(pqcm_pkg::QPSK_LEVEL);
   assign prod_neg = 32'(amplitude_ff) * (-32'(pqcm_pkg::QPSK_LEVEL));

   always_ff @(posedge clock) begin
      pos_ff <= prod_pos[30:15];
      neg_ff <= prod_neg[30:15];
   end

   // start subcarrier before the wrap
   assign kp = (req_symbol_offset < pqcm_pkg::MAX_PRS_SYMBOLS) ?
               pqcm_pkg::STAIR_TAB[comb_code_ff][req_symbol_offset] : 4'd0;
   assign re_sum = 5'(re_offset_ff) + 5'(kp);

   always_comb begin
      re_mod = '0;
      case (comb_code_ff)
         2'd0: re_mod = {3'd0, re_sum[0]};
         2'd1: re_mod = {2'd0, re_sum[1:0]};
         default: begin
            // re_sum stays below 27, so two folds by 12 then one by 6
            if (re_sum >= 5'd24) begin
               re_mod = 4'(re_sum - 5'd24);
            end else if (re_sum >= 5'd12) begin
               re_mod = 4'(re_sum - 5'd12);
            end else begin
               re_mod = re_sum[3:0];
            end
            if (comb_code_ff == 2'd2 && re_mod >= 4'd6) begin
               re_mod = re_mod - 4'd6;
            end
         end
      endcase
   end

   assign start_sum = pqcm_pkg::START_W'({rb_offset_ff, 3'b000})
                    + pqcm_pkg::START_W'({rb_offset_ff, 2'b00})
                    + pqcm_pkg::START_W'(carrier_offset_ff)
                    + pqcm_pkg::START_W'(re_mod);

   // elements per symbol: (12 / comb) * num_rb
   always_comb begin
      el_load = '0;
      case (comb_code_ff)
         2'd0:    el_load = 12'({num_rb_ff, 2'b00}) + 12'({num_rb_ff, 1'b0});
         2'd1:    el_load = 12'({num_rb_ff, 1'b0}) + 12'(num_rb_ff);
         2'd2:    el_load = 12'({num_rb_ff, 1'b0});
         default: el_load = 12'(num_rb_ff);
      endcase
   end

   // nsr_ff is the current subcarrier already reduced by the fft size
   assign step_sum = pqcm_pkg::FFT_W'(nsr_ff) + pqcm_pkg::FFT_W'(step_ff);
   assign ns_next  = (step_sum >= fft_eff) ? 12'(step_sum - fft_eff) : step_sum[11:0];

   assign last_word = (cnt_ff == pqcm_pkg::LAST_PAIR) || (el_ff == 12'd1);
   assign cfg_busy  = cfg_dirty_ff | a_busy | b_busy;
   assign accept    = req_valid & ~req_stall;

   // controller: outputs
   always_comb begin
      req_stall = 1'b1;
      emit      = 1'b0;
      cfg_start = 1'b0;
      case (state_ff)
         pqcm_pkg::ST_IDLE: begin
            req_stall = cfg_busy;
            cfg_start = cfg_dirty_ff;
         end
         pqcm_pkg::ST_DIVIDE: begin
            req_stall = 1'b1;
         end
         pqcm_pkg::ST_EMIT: begin
            emit = ~rsp_valid_ff | ~rsp_stall;
         end
         default: ;
      endcase
   end

   // controller: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pqcm_pkg::ST_IDLE: begin
            if (accept && req_first_word) begin
               state_in = pqcm_pkg::ST_DIVIDE;
            end else if (accept && el_ff != '0) begin
               state_in = pqcm_pkg::ST_EMIT;
            end
         end
         pqcm_pkg::ST_DIVIDE: begin
            if (a_done) begin
               state_in = (el_ff != '0) ? pqcm_pkg::ST_EMIT : pqcm_pkg::ST_IDLE;
            end
         end
         pqcm_pkg::ST_EMIT: begin
            if (emit && last_word) begin
               state_in = pqcm_pkg::ST_IDLE;
            end
         end
         default: state_in = pqcm_pkg::ST_IDLE;
      endcase
   end

   // remainder unit a: start subcarrier, or re-wrap after a register write
   assign a_start    = cfg_start | (accept & req_first_word);
   assign a_dividend = cfg_start ? pqcm_pkg::START_W'(ns_ff) : start_sum;

   pqcm_rem #(
      .DW (pqcm_pkg::START_W)
   ) u_rem_start (
      .clock     (clock),
      .reset     (reset),
      .start     (a_start),
      .dividend  (a_dividend),
      .divisor   (fft_eff),
      .busy      (a_busy),
      .done      (a_done),
      .remainder (a_rem)
   );

   // remainder unit b: comb step reduced by the fft size
   pqcm_rem #(
      .DW (4)
   ) u_rem_step (
      .clock     (clock),
      .reset     (reset),
      .start     (cfg_start),
      .dividend  (comb),
      .divisor   (fft_eff),
      .busy      (b_busy),
      .done      (b_done),
      .remainder (b_rem)
   );

   // reduced comb step, settled well before unit a finishes
   always_ff @(posedge clock) begin
      if (b_done) begin
         step_ff <= b_rem;
      end
   end

   // mapper datapath
   always_comb begin
      ns_in   = ns_ff;
      nsr_in  = nsr_ff;
      el_in   = el_ff;
      sym_in  = sym_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         word_in = req_gold_word;
         cnt_in  = '0;
         if (req_first_word) begin
            el_in  = el_load;
            sym_in = 5'(symbol_start_ff) + 5'(req_symbol_offset);
         end
      end
      if (a_done) begin
         nsr_in = a_rem;
         if (state_ff == pqcm_pkg::ST_DIVIDE) begin
            ns_in = a_rem;
         end
      end
      if (emit) begin
         el_in   = el_ff - 1'b1;
         word_in = {2'b00, word_ff[31:2]};
         cnt_in  = cnt_ff + 1'b1;
         ns_in   = ns_next;
         nsr_in  = ns_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pqcm_pkg::ST_IDLE;
         ns_ff    <= '0;
         nsr_ff   <= '0;
         el_ff    <= '0;
         sym_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ns_ff    <= ns_in;
         nsr_ff   <= nsr_in;
         el_ff    <= el_in;
         sym_ff   <= sym_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sym_ff <= sym_ff;
         rsp_sc_ff  <= ns_ff;
         rsp_re_ff  <= word_ff[0] ? neg_ff : pos_ff;
         rsp_im_ff  <= word_ff[1] ? neg_ff : pos_ff;
         rsp_low_ff <= last_word;
         rsp_los_ff <= (el_ff == 12'd1);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_symbol_index   = rsp_sym_ff;
   assign rsp_subcarrier     = rsp_sc_ff;
   assign rsp_sample_real    = rsp_re_ff;
   assign rsp_sample_imag    = rsp_im_ff;
   assign rsp_last_of_word   = rsp_low_ff;
   assign rsp_last_of_symbol = rsp_los_ff;

endmodule

FILE: hdl/pqcm_checker.sv
// ----------------------------------------------------------------------------
// pqcm_checker
// Port-level checks on the PRS QPSK comb mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pqcm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [11:0]        rsp_subcarrier,
   input logic signed [15:0] rsp_sample_real,
   input logic signed [15:0] rsp_sample_imag,
   input logic               rsp_last_of_word,
   input logic               rsp_last_of_symbol
);

   // a held word keeps its subcarrier
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_subcarrier))
      else $error("rsp word changed while stalled");

   // the end of a symbol always closes the word
   a_sym_ends_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_symbol |-> rsp_last_of_word)
      else $error("last_of_symbol without last_of_word");

   // both components come from the same scaled level, up to sign
   a_qpsk_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_real == rsp_sample_imag)
                 || (rsp_sample_real == -rsp_sample_imag)
                 || (rsp_sample_real == ~rsp_sample_imag))
      else $error("real and imag parts of unequal magnitude");

   // nothing shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind prs_qpsk_comb_mapper_core pqcm_checker u_pqcm_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_subcarrier     (rsp_subcarrier),
   .rsp_sample_real    (rsp_sample_real),
   .rsp_sample_imag    (rsp_sample_imag),
   .rsp_last_of_word   (rsp_last_of_word),
   .rsp_last_of_symbol (rsp_last_of_symbol)
);
